// File: sv/llag_pkg.sv
// Shared types, codes and constants of the life-like automaton generation block.
package llag_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam int MASK_W    = 9;
    localparam int DIM_W     = 7;
    localparam int CNT_W     = 4;
    localparam int OP_W      = 2;
    localparam int POS_W     = 6;
    localparam int CFG_IDX_W = 2;

    typedef logic [OP_W-1:0] t_opcode;
    localparam t_opcode OP_WRITE = 2'd0;
    localparam t_opcode OP_STEP  = 2'd1;
    localparam t_opcode OP_READ  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BIRTH   = 2'd0;
    localparam t_cfg_idx CFG_SURVIVE = 2'd1;
    localparam t_cfg_idx CFG_ROWS    = 2'd2;
    localparam t_cfg_idx CFG_COLS    = 2'd3;

    localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;
    localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;
    localparam logic [DIM_W-1:0]  DIM_RST     = 7'd64;

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } t_state;

    typedef struct packed {
        logic shift;
        logic wr;
        logic din;
    } t_cell_ctrl;

    // Width that holds both a 7-bit size register and the largest grid dimension.
    function automatic int dim_w(input int max_n);
        int w;
        w = $clog2(max_n + 1);
        return (w > DIM_W) ? w : DIM_W;
    endfunction

endpackage

// File: sv/life_like_automaton_generation_top.sv
// Top level of the life-like automaton: row chain, rule unit, control and result register.
//
//  Channel | Direction | Handshake                   | Payload
//  --------+-----------+-----------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready     | i_opcode, i_row, i_col, i_cell_in
//  out     | output    | o_out_valid / i_out_ready   | o_cell_out
//  cfg     | input     | i_cfg_we                    | i_cfg_idx, i_cfg_data
//
// A cell write or read is taken while the control is idle, and a read word is registered in the cycle after.
// A step is taken while idle and then holds the input off while the row chain rotates
// once through the rule unit, one row per cycle.
// Reset is synchronous; it clears the grid and the control and loads the rule and size
// registers with their defaults.
// A pending read word does not block writes or steps, only the next read.
module life_like_automaton_generation_top #(
    parameter int MAX_ROWS = llag_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = llag_pkg::MAX_COLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [llag_pkg::OP_W-1:0]       i_opcode,
    input  logic [llag_pkg::POS_W-1:0]      i_row,
    input  logic [llag_pkg::POS_W-1:0]      i_col,
    input  logic                            i_cell_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_cell_out,
    input  logic                            i_cfg_we,
    input  logic [llag_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [llag_pkg::MASK_W-1:0]     i_cfg_data
);

    localparam int RW  = llag_pkg::dim_w(MAX_ROWS);
    localparam int CW  = llag_pkg::dim_w(MAX_COLS);
    localparam int RIW = $clog2(MAX_ROWS);

    logic [llag_pkg::MASK_W-1:0] r_birth;
    logic [llag_pkg::MASK_W-1:0] r_survive;
    logic [llag_pkg::DIM_W-1:0]  r_act_rows;
    logic [llag_pkg::DIM_W-1:0]  r_act_cols;

    llag_pkg::t_state r_state;
    llag_pkg::t_state n_state;
    logic [RIW-1:0]   r_cnt;
    logic [RIW-1:0]   n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_cell_out;
    logic             n_cell_out;
    logic [MAX_COLS-1:0] r_saved;

    logic [RW-1:0]       w_eff_rows;
    logic [CW-1:0]       w_eff_cols;
    logic                w_inside;
    logic                w_accept;
    logic                w_wr_fire;
    logic                w_rd_fire;
    logic                w_shift;
    logic                w_last;
    logic                w_row_int;
    logic [MAX_ROWS-1:0] w_row_hot;
    logic [MAX_COLS-1:0] w_col_hot;
    logic [MAX_ROWS-1:0] w_rd_bits;
    logic [MAX_COLS-1:0] w_rows [MAX_ROWS];
    logic [MAX_COLS-1:0] w_new_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth    <= llag_pkg::BIRTH_RST;
            r_survive  <= llag_pkg::SURVIVE_RST;
            r_act_rows <= llag_pkg::DIM_RST;
            r_act_cols <= llag_pkg::DIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                llag_pkg::CFG_BIRTH:   r_birth    <= i_cfg_data;
                llag_pkg::CFG_SURVIVE: r_survive  <= i_cfg_data;
                llag_pkg::CFG_ROWS:    r_act_rows <= i_cfg_data[llag_pkg::DIM_W-1:0];
                llag_pkg::CFG_COLS:    r_act_cols <= i_cfg_data[llag_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_eff_rows = (RW'(r_act_rows) > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(r_act_rows);
    assign w_eff_cols = (CW'(r_act_cols) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(r_act_cols);
    assign w_inside   = (RW'(i_row) < w_eff_rows) && (CW'(i_col) < w_eff_cols);

    for (genvar gy = 0; gy < MAX_ROWS; gy++) begin : g_row_hot
        assign w_row_hot[gy] = (32'(i_row) == gy);
    end
    for (genvar gx = 0; gx < MAX_COLS; gx++) begin : g_col_hot
        assign w_col_hot[gx] = (32'(i_col) == gx);
    end

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_wr_fire = w_accept && (i_opcode == llag_pkg::OP_WRITE) && w_inside;
    assign w_rd_fire = w_accept && (i_opcode == llag_pkg::OP_READ);
    assign w_last    = (r_cnt == RIW'(MAX_ROWS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            llag_pkg::ST_IDLE: begin
                if (w_accept && i_opcode == llag_pkg::OP_STEP) begin
                    n_state = llag_pkg::ST_STEP;
                end
            end
            llag_pkg::ST_STEP: begin
                if (w_last) begin
                    n_state = llag_pkg::ST_IDLE;
                end
            end
            default: n_state = llag_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_shift    = 1'b0;
        case (r_state)
            llag_pkg::ST_IDLE: begin
                o_in_ready = (i_opcode != llag_pkg::OP_READ) || !r_out_valid || i_out_ready;
            end
            llag_pkg::ST_STEP: begin
                w_shift = 1'b1;
            end
            default: ;
        endcase
    end

    assign n_cnt = (w_shift && !w_last) ? r_cnt + RIW'(1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= llag_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // The row leaving the head of the chain is the row whose index equals the counter.
    assign w_row_int = (r_cnt != '0) && ((RW'(r_cnt) + RW'(1)) < w_eff_rows);

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_saved <= w_rows[0];
        end
    end

    for (genvar gy = 0; gy < MAX_ROWS; gy++) begin : g_cell
        llag_pkg::t_cell_ctrl w_ctrl;
        logic [MAX_COLS-1:0]  w_next;

        assign w_ctrl.shift = w_shift;
        assign w_ctrl.wr    = w_wr_fire && w_row_hot[gy];
        assign w_ctrl.din   = i_cell_in;

        if (gy == MAX_ROWS - 1) begin : g_tail
            assign w_next = w_new_row;
        end else begin : g_body
            assign w_next = w_rows[gy+1];
        end

        llag_row_cell #(
            .MAX_COLS(MAX_COLS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_col_hot  (w_col_hot),
            .i_next_row (w_next),
            .o_row      (w_rows[gy]),
            .o_rd_bit   (w_rd_bits[gy])
        );
    end

    llag_rule_row #(
        .MAX_COLS(MAX_COLS)
    ) u_rule (
        .i_above    (r_saved),
        .i_mid      (w_rows[0]),
        .i_below    (w_rows[1]),
        .i_birth    (r_birth),
        .i_survive  (r_survive),
        .i_eff_cols (w_eff_cols),
        .i_row_int  (w_row_int),
        .o_row      (w_new_row)
    );

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_cell_out  = r_cell_out;
        if (w_rd_fire) begin
            n_out_valid = 1'b1;
            n_cell_out  = w_inside && |(w_rd_bits & w_row_hot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell_out <= n_cell_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_cell_out  = r_cell_out;

endmodule

// File: sv/llag_row_cell.sv
// One grid row held as a cell of the row chain, with cell write, cell read and shift.
module llag_row_cell #(
    parameter int MAX_COLS = llag_pkg::MAX_COLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  llag_pkg::t_cell_ctrl  i_ctrl,
    input  logic [MAX_COLS-1:0]   i_col_hot,
    input  logic [MAX_COLS-1:0]   i_next_row,
    output logic [MAX_COLS-1:0]   o_row,
    output logic                  o_rd_bit
);

    logic [MAX_COLS-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_ctrl.shift) begin
            r_row <= i_next_row;
        end else if (i_ctrl.wr) begin
            r_row <= (r_row & ~i_col_hot) | (i_col_hot & {MAX_COLS{i_ctrl.din}});
        end
    end

    assign o_row    = r_row;
    assign o_rd_bit = |(r_row & i_col_hot);

endmodule

// File: sv/llag_rule_row.sv
// Next generation of one row from the row itself, the rows above and below and the rule masks.
module llag_rule_row #(
    parameter int MAX_COLS = llag_pkg::MAX_COLS_DEF
) (
    input  logic [MAX_COLS-1:0]                 i_above,
    input  logic [MAX_COLS-1:0]                 i_mid,
    input  logic [MAX_COLS-1:0]                 i_below,
    input  logic [llag_pkg::MASK_W-1:0]         i_birth,
    input  logic [llag_pkg::MASK_W-1:0]         i_survive,
    input  logic [llag_pkg::dim_w(MAX_COLS)-1:0] i_eff_cols,
    input  logic                                i_row_int,
    output logic [MAX_COLS-1:0]                 o_row
);

    localparam int CW    = llag_pkg::dim_w(MAX_COLS);
    localparam int CNT_W = llag_pkg::CNT_W;

    for (genvar gx = 0; gx < MAX_COLS; gx++) begin : g_col
        if (gx == 0 || gx == MAX_COLS - 1) begin : g_edge
            assign o_row[gx] = i_mid[gx];
        end else begin : g_inner
            logic [CNT_W-1:0] w_cnt;
            logic             w_col_int;

            assign w_cnt = CNT_W'(i_above[gx-1]) + CNT_W'(i_above[gx]) + CNT_W'(i_above[gx+1])
                         + CNT_W'(i_mid[gx-1]) + CNT_W'(i_mid[gx+1])
                         + CNT_W'(i_below[gx-1]) + CNT_W'(i_below[gx]) + CNT_W'(i_below[gx+1]);
            assign w_col_int = (CW'(gx + 1) < i_eff_cols);
            assign o_row[gx] = (w_col_int && i_row_int)
                             ? (i_mid[gx] ? i_survive[w_cnt] : i_birth[w_cnt])
                             : i_mid[gx];
        end
    end

endmodule

// File: sv/llag_checker.sv
// Port-level checks of the life-like automaton top level, bound to it.
module llag_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [llag_pkg::OP_W-1:0]  i_opcode,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_cell_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cell_out))
        else $error("Read word changed or dropped while stalled.");

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == llag_pkg::OP_STEP) |=> !o_in_ready)
        else $error("New word taken right after a step was started.");

    a_word_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && (i_opcode == llag_pkg::OP_READ)))
        else $error("Read word appeared without an accepted read.");

    a_read_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && (i_opcode == llag_pkg::OP_READ) && o_out_valid && !i_out_ready
            |-> !o_in_ready)
        else $error("Read taken while the previous read word is stalled.");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready
            && !$past(i_in_valid && o_in_ready && (i_opcode == llag_pkg::OP_READ))
            |=> !o_out_valid || $past(i_in_valid && o_in_ready
                && (i_opcode == llag_pkg::OP_READ)))
        else $error("Read word repeated after it was taken.");

endmodule

bind life_like_automaton_generation_top llag_checker u_llag_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the life-like automaton: predicts every cell read word.
module tb;

    localparam int GRID_R      = llag_pkg::MAX_ROWS_DEF;
    localparam int GRID_C      = llag_pkg::MAX_COLS_DEF;
    localparam int MW          = llag_pkg::MASK_W;
    localparam int PW          = llag_pkg::POS_W;
    localparam int DW          = llag_pkg::DIM_W;
    localparam int SETTLE      = GRID_R + 16;
    localparam int QUIET_LIMIT = 4000;
    localparam llag_pkg::t_opcode OP_UNUSED = 2'd3;

    typedef struct {
        llag_pkg::t_opcode op;
        logic [PW-1:0]     row;
        logic [PW-1:0]     col;
        logic              cell_val;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              o_in_ready;
    llag_pkg::t_opcode in_op = llag_pkg::OP_WRITE;
    logic [PW-1:0]     in_row = '0;
    logic [PW-1:0]     in_col = '0;
    logic              in_cell = 1'b0;
    logic              o_out_valid;
    logic              out_ready = 1'b0;
    logic              o_cell_out;
    logic              cfg_we = 1'b0;
    llag_pkg::t_cfg_idx cfg_idx = llag_pkg::CFG_BIRTH;
    logic [MW-1:0]     cfg_data = '0;

    // Predicted grid, rule and size registers.
    logic [GRID_C-1:0] cells [GRID_R];
    logic [MW-1:0] birth_rule = llag_pkg::BIRTH_RST;
    logic [MW-1:0] survive_rule = llag_pkg::SURVIVE_RST;
    logic [DW-1:0] rows_reg = llag_pkg::DIM_RST;
    logic [DW-1:0] cols_reg = llag_pkg::DIM_RST;

    t_word word_q [$];
    logic  cell_reads_due [$];
    t_word next_word;
    logic  due_cell;
    bit    steady_run = 1'b0;
    int    errors = 0;
    int    quiet = 0;

    life_like_automaton_generation_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (in_op),
        .i_row       (in_row),
        .i_col       (in_col),
        .i_cell_in   (in_cell),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_cell_out  (o_cell_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_dim(logic [DW-1:0] v, int limit);
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    function automatic void advance_generation(int nr, int nc);
        logic [GRID_C-1:0] prev [GRID_R];
        int n;
        logic [MW-1:0] rule;
        if (nr < 3 || nc < 3) return;
        prev = cells;
        for (int y = 1; y < nr - 1; y++) begin
            for (int x = 1; x < nc - 1; x++) begin
                n = 0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        if (dy != 0 || dx != 0) n += int'(prev[y + dy][x + dx]);
                    end
                end
                rule = prev[y][x] ? survive_rule : birth_rule;
                cells[y][x] = rule[n];
            end
        end
    endfunction

    function automatic void grid_apply(llag_pkg::t_opcode op, logic [PW-1:0] r,
                                       logic [PW-1:0] c, logic v);
        int  nr;
        int  nc;
        logic in_area;
        nr = eff_dim(rows_reg, GRID_R);
        nc = eff_dim(cols_reg, GRID_C);
        in_area = (int'(r) < nr) && (int'(c) < nc);
        case (op)
            llag_pkg::OP_WRITE: begin
                if (in_area) cells[r][c] = v;
            end
            llag_pkg::OP_STEP: begin
                advance_generation(nr, nc);
            end
            llag_pkg::OP_READ: begin
                cell_reads_due.push_back(in_area ? cells[r][c] : 1'b0);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void push_word(llag_pkg::t_opcode op, int r, int c, logic v);
        t_word w;
        w.op = op;
        w.row = PW'(r);
        w.col = PW'(c);
        w.cell_val = v;
        word_q.push_back(w);
    endfunction

    function automatic void fill_area();
        int nr;
        int nc;
        nr = eff_dim(rows_reg, GRID_R);
        nc = eff_dim(cols_reg, GRID_C);
        if (nr * nc > 256) return;
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                push_word(llag_pkg::OP_WRITE, r, c, 1'($urandom_range(1)));
            end
        end
    endfunction

    function automatic void push_random_words(int count);
        int nr;
        int nc;
        int pick;
        llag_pkg::t_opcode op;
        int r;
        int c;
        nr = eff_dim(rows_reg, GRID_R);
        nc = eff_dim(cols_reg, GRID_C);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 44) op = llag_pkg::OP_WRITE;
            else if (pick < 51) op = llag_pkg::OP_STEP;
            else if (pick < 96) op = llag_pkg::OP_READ;
            else op = OP_UNUSED;
            r = ($urandom_range(9) == 0 || nr == 0) ? $urandom_range(63) : $urandom_range(nr - 1);
            c = ($urandom_range(9) == 0 || nc == 0) ? $urandom_range(63) : $urandom_range(nc - 1);
            push_word(op, r, c, 1'($urandom_range(1)));
        end
    endfunction

    task automatic report(string what);
        errors++;
        $display("tb: mismatch at %0t: %s", $time, what);
    endtask

    // Waits until every word is taken and every read word is back, then lets a step finish.
    task automatic settle();
        do @(negedge i_clk);
        while (word_q.size() != 0 || in_valid || cell_reads_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_rules(logic [MW-1:0] b, logic [MW-1:0] s,
                              logic [MW-1:0] r, logic [MW-1:0] c);
        llag_pkg::t_cfg_idx idx [4];
        logic [MW-1:0]      val [4];
        idx = '{llag_pkg::CFG_BIRTH, llag_pkg::CFG_SURVIVE, llag_pkg::CFG_ROWS,
                llag_pkg::CFG_COLS};
        val = '{b, s, r, c};
        for (int i = 0; i < 4; i++) begin
            @(posedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= idx[i];
            cfg_data <= val[i];
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
        birth_rule   = b;
        survive_rule = s;
        rows_reg     = r[DW-1:0];
        cols_reg     = c[DW-1:0];
    endtask

    task automatic next_phase(logic [MW-1:0] b, logic [MW-1:0] s,
                              logic [MW-1:0] r, logic [MW-1:0] c, bit calm);
        settle();
        steady_run = calm;
        load_rules(b, s, r, c);
    endtask

    // Driver: offers the next word when the channel is free, with random gaps unless in a steady run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) grid_apply(in_op, in_row, in_col, in_cell);
            if (!in_valid || o_in_ready) begin
                if (word_q.size() != 0 && (steady_run || $urandom_range(99) >= 18)) begin
                    next_word = word_q.pop_front();
                    in_valid <= 1'b1;
                    in_op    <= next_word.op;
                    in_row   <= next_word.row;
                    in_col   <= next_word.col;
                    in_cell  <= next_word.cell_val;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each read word against the oldest predicted cell.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (cell_reads_due.size() == 0) begin
                    report("read word with no read outstanding");
                end else begin
                    due_cell = cell_reads_due.pop_front();
                    if (o_cell_out !== due_cell)
                        report($sformatf("cell_out %b, predicted %b", o_cell_out, due_cell));
                end
            end
            out_ready <= steady_run || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        for (int r = 0; r < GRID_R; r++) cells[r] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corners at full size, a blinker under the default rule, and an unused opcode.
        push_word(llag_pkg::OP_WRITE, 0, 0, 1'b1);
        push_word(llag_pkg::OP_WRITE, 63, 63, 1'b1);
        push_word(llag_pkg::OP_WRITE, 63, 0, 1'b1);
        push_word(llag_pkg::OP_WRITE, 0, 63, 1'b1);
        push_word(llag_pkg::OP_READ, 0, 0, 1'b0);
        push_word(llag_pkg::OP_READ, 63, 63, 1'b0);
        push_word(llag_pkg::OP_READ, 63, 0, 1'b0);
        push_word(llag_pkg::OP_READ, 0, 63, 1'b0);
        push_word(llag_pkg::OP_WRITE, 10, 9, 1'b1);
        push_word(llag_pkg::OP_WRITE, 10, 10, 1'b1);
        push_word(llag_pkg::OP_WRITE, 10, 11, 1'b1);
        push_word(llag_pkg::OP_STEP, 0, 0, 1'b0);
        push_word(llag_pkg::OP_READ, 9, 10, 1'b0);
        push_word(llag_pkg::OP_READ, 10, 10, 1'b0);
        push_word(llag_pkg::OP_READ, 11, 10, 1'b0);
        push_word(llag_pkg::OP_READ, 10, 9, 1'b0);
        push_word(OP_UNUSED, 63, 63, 1'b1);
        push_word(llag_pkg::OP_READ, 0, 0, 1'b0);

        // Writes and reads outside a small area.
        next_phase(9'd8, 9'd12, 9'd5, 9'd6, 1'b0);
        push_word(llag_pkg::OP_WRITE, 5, 2, 1'b1);
        push_word(llag_pkg::OP_WRITE, 2, 6, 1'b1);
        push_word(llag_pkg::OP_READ, 63, 63, 1'b0);
        push_word(llag_pkg::OP_READ, 5, 0, 1'b0);
        push_word(llag_pkg::OP_STEP, 0, 0, 1'b0);

        next_phase(9'h1FF, 9'h000, 9'd3, 9'd3, 1'b0);
        fill_area();
        push_random_words(120);

        next_phase(9'h000, 9'h1FF, 9'd64, 9'd64, 1'b0);
        push_word(llag_pkg::OP_READ, 63, 63, 1'b0);
        push_word(llag_pkg::OP_READ, 0, 63, 1'b0);
        push_random_words(150);

        next_phase(9'd8, 9'd12, 9'd8, 9'd10, 1'b0);
        fill_area();
        push_random_words(250);

        for (int p = 0; p < 5; p++) begin
            next_phase(MW'($urandom_range(511)), MW'($urandom_range(511)),
                       MW'($urandom_range(3, 16)), MW'($urandom_range(3, 16)), 1'b0);
            fill_area();
            push_random_words(100);
        end

        next_phase(MW'($urandom_range(511)), MW'($urandom_range(511)),
                   9'd2, 9'd9, 1'b0);
        fill_area();
        push_random_words(60);

        // Upper data bits fall outside the size register.
        next_phase(9'h1FF, MW'($urandom_range(511)), 9'h1C5, 9'd100, 1'b1);
        push_random_words(150);

        next_phase(9'd8, 9'd12, 9'd0, 9'd0, 1'b0);
        push_random_words(40);

        settle();
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
